>>> hdl/dihs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dihs_pkg
// Shared types, constants and the key hash for the device id hash set.
// ----------------------------------------------------------------------------
package dihs_pkg;

   // default sizing of the table
   localparam int TABLE_SLOTS_DEF = 64;
   localparam int MAX_ENTRIES_DEF = 16;

   // leading key bytes that take part in hashing and compare
   localparam int KEY_BYTES = 8;

   // rotate-xor hash shifts
   localparam int HASH_SHL = 5;
   localparam int HASH_SHR = 27;

   localparam logic [63:0] KEY_MASK = ~64'd0 << (64 - 8 * KEY_BYTES);

   typedef enum logic [1:0] {
      CMD_ADD      = 2'd0,
      CMD_REMOVE   = 2'd1,
      CMD_CONTAINS = 2'd2,
      CMD_CLEAR    = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [63:0] key;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [4:0] entry_count;
   } rsp_type;

   // one table entry as held in the slot memory
   typedef struct packed {
      logic        occupied;
      logic        tombstone;
      logic [63:0] key;
   } slot_type;

   // rotate-xor over the leading key bytes, bits 63:56 first
   function automatic logic [31:0] hash_key(input logic [63:0] key);
      logic [31:0] h;
      logic [7:0]  b;
      h = 32'd0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         b = key[63 - 8 * i -: 8];
         h = (h << HASH_SHL) ^ (h >> HASH_SHR) ^ {24'd0, b};
      end
      return h;
   endfunction

endpackage
`default_nettype wire

>>> hdl/dihs_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dihs_table
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dihs_table #(
   parameter int TABLE_SLOTS = dihs_pkg::TABLE_SLOTS_DEF,
   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [IDX_W-1:0]   wr_addr,
   input  wire dihs_pkg::slot_type wr_slot,
   input  wire logic [IDX_W-1:0]   rd_addr,
   output dihs_pkg::slot_type      rd_slot
);
   import dihs_pkg::*;

   slot_type slot_mem [TABLE_SLOTS];
   slot_type rd_slot_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_slot;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_slot_ff <= slot_mem[rd_addr];
   end

   assign rd_slot = rd_slot_ff;

endmodule
`default_nettype wire

>>> hdl/device_id_hash_set.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// device_id_hash_set
// Set of 64-bit device ids in an open-addressed table with linear probing
// and tombstones. Commands: add, remove, contains, clear.
//
//   channel  | ports                           | direction
//   ---------+---------------------------------+----------
//   request  | req_valid, req_ready, req_word  | in
//   response | rsp_valid, rsp_ready, rsp_word  | out
//
// An add, remove or contains reads the home slot, then probes slots in
// turn: one read of the slot memory per cycle, one slot per probe.
// Add at the entry limit goes straight to the response. Clear sweeps the
// slot memory, one slot per cycle, and then responds.
// After reset the same sweep runs over every slot with req_ready low.
// A new request is taken while the previous response still waits on rsp_ready.
// ----------------------------------------------------------------------------
module device_id_hash_set #(
   parameter int TABLE_SLOTS = dihs_pkg::TABLE_SLOTS_DEF,
   parameter int MAX_ENTRIES = dihs_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dihs_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dihs_pkg::rsp_type      rsp_word
);
   import dihs_pkg::*;

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] probe_ff, probe_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic             res_ok_ff, res_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_word_ff, rsp_word_in;
   cmd_type          cmd_ff, cmd_in;
   logic [63:0]      key_ff, key_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_type         wr_slot;
   logic [IDX_W-1:0] rd_addr;
   slot_type         rd_slot;

   logic [63:0]      req_key;
   logic [31:0]      home_hash;
   logic [IDX_W-1:0] home_idx;
   logic [IDX_W-1:0] next_idx;
   logic             key_hit;
   logic             accept;
   logic             out_free;
   logic [CNT_W+4:0] live_wide;

   // home slot of the incoming key
   assign req_key   = req_word.key & KEY_MASK;
   assign home_hash = hash_key(req_key) & 32'(TABLE_SLOTS - 1);
   assign home_idx  = home_hash[IDX_W-1:0];

   // probe step, wrapping at the table end
   assign next_idx  = (idx_ff == LAST_SLOT) ? '0 : idx_ff + 1'b1;
   assign key_hit   = (rd_slot.key == key_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign live_wide = {5'd0, live_ff};

   // slot memory
   dihs_table #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_slot (wr_slot),
      .rd_addr (rd_addr),
      .rd_slot (rd_slot)
   );

   // next state, memory access and result
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      probe_in     = probe_ff;
      live_in      = live_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_slot      = '{occupied: 1'b1, tombstone: 1'b0, key: key_ff};
      rd_addr      = idx_ff;

      case (state_ff)
         // sweep every slot to empty
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_slot = '{occupied: 1'b0, tombstone: 1'b0, key: 64'd0};
            if (idx_ff == LAST_SLOT) begin
               idx_in   = '0;
               state_in = (cmd_ff == CMD_CLEAR) ? ST_RESP : ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // take a word, start the home slot read
         ST_IDLE: begin
            rd_addr = home_idx;
            if (accept) begin
               cmd_in   = req_word.cmd;
               key_in   = req_key;
               idx_in   = home_idx;
               probe_in = '0;
               if (req_word.cmd == CMD_CLEAR) begin
                  idx_in    = '0;
                  live_in   = '0;
                  res_ok_in = 1'b1;
                  state_in  = ST_CLEAR;
               end else if (req_word.cmd == CMD_ADD &&
                            live_ff >= CNT_W'(MAX_ENTRIES)) begin
                  res_ok_in = 1'b0;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end

         // examine one slot, read the next one
         ST_CHECK: begin
            rd_addr   = next_idx;
            idx_in    = next_idx;
            probe_in  = probe_ff + 1'b1;
            res_ok_in = 1'b0;
            if (probe_ff == LAST_SLOT) begin
               state_in = ST_RESP;
            end
            if (cmd_ff == CMD_ADD) begin
               if (!rd_slot.occupied) begin
                  wr_en     = 1'b1;
                  live_in   = live_ff + 1'b1;
                  res_ok_in = 1'b1;
                  state_in  = ST_RESP;
               end else if (key_hit) begin
                  state_in = ST_RESP;
               end
            end else begin
               if (!rd_slot.occupied && !rd_slot.tombstone) begin
                  state_in = ST_RESP;
               end else if (rd_slot.occupied && key_hit) begin
                  res_ok_in = 1'b1;
                  state_in  = ST_RESP;
                  if (cmd_ff == CMD_REMOVE) begin
                     wr_en   = 1'b1;
                     wr_slot = '{occupied: 1'b0, tombstone: 1'b1, key: rd_slot.key};
                     if (live_ff != '0) begin
                        live_in = live_ff - 1'b1;
                     end
                  end
               end
            end
         end

         // hand the result to the output register
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{ok: res_ok_ff, entry_count: live_wide[4:0]};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= CMD_ADD;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
      end
      probe_ff    <= probe_in;
      res_ok_ff   <= res_ok_in;
      rsp_word_ff <= rsp_word_in;
      key_ff      <= key_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

>>> hdl/dihs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dihs_checker
// Port-level checks on the device id hash set, bound to the top level.
// ----------------------------------------------------------------------------
module dihs_checker #(
   parameter int MAX_ENTRIES = dihs_pkg::MAX_ENTRIES_DEF
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire dihs_pkg::req_type req_word,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire dihs_pkg::rsp_type rsp_word
);
   import dihs_pkg::*;

   logic [4:0] last_cnt_ff;
   logic [4:0] last_cnt_in;

   assign last_cnt_in = (rsp_valid && rsp_ready) ? rsp_word.entry_count : last_cnt_ff;

   // count carried by the last delivered word
   always_ff @(posedge clock) begin
      if (reset) begin
         last_cnt_ff <= 5'd0;
      end else begin
         last_cnt_ff <= last_cnt_in;
      end
   end

   // a stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response dropped or changed while stalled");

   // clearing pass keeps requests out right after reset
   a_reset_sweep: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during the clearing pass");

   // count stays within the entry limit, checked for limits below 32
   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (MAX_ENTRIES >= 32) || (rsp_word.entry_count <= 5'(MAX_ENTRIES)))
      else $error("entry count above the limit");

   // one command moves the count by at most one, or clears it
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |->
         rsp_word.entry_count == 5'd0 ||
         rsp_word.entry_count == last_cnt_ff ||
         rsp_word.entry_count == last_cnt_ff + 5'd1 ||
         rsp_word.entry_count == last_cnt_ff - 5'd1)
      else $error("entry count jumped");

   // a waiting request word stays until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_word))
      else $error("request dropped or changed while waiting");

endmodule

bind device_id_hash_set dihs_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_dihs_checker (.*);
`default_nettype wire
